FILE: sv/odwm_pkg.sv
// Shared types, constants and tables for the omni-drive wheel mixer.
`timescale 1ns / 1ps

package odwm_pkg;

    // Field widths
    localparam int SPEED_W   = 7;
    localparam int HEADING_W = 11;
    localparam int TRIM_W    = 8;
    localparam int WHEEL_W   = 9;
    localparam int N_WHEELS  = 4;

    // Tangent scaling: Q.TAN_FRAC_BITS, tan(45) is exactly 1.0
    localparam int TAN_FRAC_BITS = 12;
    localparam int TQ_W          = TAN_FRAC_BITS + 1;
    localparam int TAN_SRC_FRAC  = 16;
    localparam int TAN_SRC_W     = TAN_SRC_FRAC + 1;
    localparam int TAN_ENTRIES   = 46;
    localparam int ARG_W         = 6;

    // Angle constants
    localparam int ANGLE_SHIFT = 315;
    localparam int FULL_TURN   = 360;
    localparam int OCT_SPAN    = 45;
    localparam int ANGLE_W     = 9;
    localparam int OCT_W       = 3;
    localparam int N_OCTANTS   = 8;

    // Wheel term selector: sign and magnitude source
    typedef enum logic [1:0] {
        TERM_POS_S,
        TERM_NEG_S,
        TERM_POS_T,
        TERM_NEG_T
    } term_t;

    // Octant decode result carried from the angle stage to the mixing stage
    typedef struct packed {
        logic [SPEED_W-1:0]       speed;
        logic signed [TRIM_W-1:0] trim;
        logic [OCT_W-1:0]         oct;
        logic [TQ_W-1:0]          tq;
    } angle_cmd_t;

    // round(tan(d deg) * 2^16), d = 0..45
    localparam logic [TAN_SRC_W-1:0] TAN_Q16 [TAN_ENTRIES] = '{
        17'd0,     17'd1144,  17'd2289,  17'd3435,  17'd4583,  17'd5734,
        17'd6888,  17'd8047,  17'd9210,  17'd10380, 17'd11556, 17'd12739,
        17'd13930, 17'd15130, 17'd16340, 17'd17560, 17'd18792, 17'd20036,
        17'd21294, 17'd22566, 17'd23853, 17'd25157, 17'd26478, 17'd27818,
        17'd29179, 17'd30560, 17'd31964, 17'd33392, 17'd34846, 17'd36327,
        17'd37837, 17'd39378, 17'd40951, 17'd42560, 17'd44205, 17'd45889,
        17'd47615, 17'd49385, 17'd51202, 17'd53070, 17'd54991, 17'd56970,
        17'd59009, 17'd61113, 17'd63287, 17'd65536
    };

    // Per octant, per wheel (wheel one first)
    localparam term_t OCT_MAP [N_OCTANTS][N_WHEELS] = '{
        '{TERM_NEG_S, TERM_POS_T, TERM_POS_S, TERM_NEG_T},
        '{TERM_NEG_T, TERM_POS_S, TERM_POS_T, TERM_NEG_S},
        '{TERM_POS_T, TERM_POS_S, TERM_NEG_T, TERM_NEG_S},
        '{TERM_POS_S, TERM_POS_T, TERM_NEG_S, TERM_NEG_T},
        '{TERM_POS_S, TERM_NEG_T, TERM_NEG_S, TERM_POS_T},
        '{TERM_POS_T, TERM_NEG_S, TERM_NEG_T, TERM_POS_S},
        '{TERM_NEG_T, TERM_NEG_S, TERM_POS_T, TERM_POS_S},
        '{TERM_NEG_S, TERM_NEG_T, TERM_POS_S, TERM_POS_T}
    };

    // Bring a Q16 tangent entry to Q.TAN_FRAC_BITS with rounding
    function automatic logic [TQ_W-1:0] tan_q(input logic [ARG_W-1:0] arg);
        logic [TAN_SRC_W+TAN_FRAC_BITS-1:0] wide;
        wide = ({{TAN_FRAC_BITS{1'b0}}, TAN_Q16[arg]} << TAN_FRAC_BITS)
             + (TAN_SRC_W+TAN_FRAC_BITS)'(1 << (TAN_SRC_FRAC - 1));
        return wide[TAN_SRC_FRAC+TAN_FRAC_BITS:TAN_SRC_FRAC];
    endfunction

endpackage

FILE: sv/odwm_angle_stage.sv
// Heading reduction, octant split and tangent lookup, registered.
`timescale 1ns / 1ps

module odwm_angle_stage
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [odwm_pkg::SPEED_W-1:0]         speed,
    input  logic signed [odwm_pkg::HEADING_W-1:0] heading_deg,
    input  logic signed [odwm_pkg::TRIM_W-1:0]   turn_offset,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output odwm_pkg::angle_cmd_t                 out_cmd
);

    // Offset keeps the shifted heading positive over the whole input range
    localparam int SUM_W    = odwm_pkg::HEADING_W + 1;
    localparam int BIAS     = odwm_pkg::ANGLE_SHIFT + 2 * odwm_pkg::FULL_TURN;
    localparam int STEP_4   = 4 * odwm_pkg::FULL_TURN;
    localparam int STEP_2   = 2 * odwm_pkg::FULL_TURN;
    localparam int STEP_1   = odwm_pkg::FULL_TURN;

    logic [SUM_W-1:0]                  sum0;
    logic [SUM_W-1:0]                  sum1;
    logic [SUM_W-1:0]                  sum2;
    logic [SUM_W-1:0]                  sum3;
    logic [odwm_pkg::ANGLE_W-1:0]      angle;
    logic [odwm_pkg::OCT_W-1:0]        oct;
    logic [odwm_pkg::ANGLE_W-1:0]      oct_base;
    logic [odwm_pkg::ARG_W-1:0]        rem;
    logic [odwm_pkg::ARG_W-1:0]        arg;
    odwm_pkg::angle_cmd_t              cmd_next;
    odwm_pkg::angle_cmd_t              cmd_reg;
    logic                              valid_reg;
    logic                              valid_next;

    // Reduce modulo 360 by three compare-and-subtract steps
    always_comb
    begin
        sum0 = SUM_W'(unsigned'(SUM_W'(heading_deg))) + SUM_W'(BIAS);
        sum1 = (sum0 >= SUM_W'(STEP_4)) ? sum0 - SUM_W'(STEP_4) : sum0;
        sum2 = (sum1 >= SUM_W'(STEP_2)) ? sum1 - SUM_W'(STEP_2) : sum1;
        sum3 = (sum2 >= SUM_W'(STEP_1)) ? sum2 - SUM_W'(STEP_1) : sum2;
        angle = sum3[odwm_pkg::ANGLE_W-1:0];
    end

    // Octant by parallel threshold compares
    always_comb
    begin
        oct      = '0;
        oct_base = '0;
        for (int k = 1; k < odwm_pkg::N_OCTANTS; k++)
        begin
            if (angle >= odwm_pkg::ANGLE_W'(k * odwm_pkg::OCT_SPAN))
            begin
                oct      = odwm_pkg::OCT_W'(k);
                oct_base = odwm_pkg::ANGLE_W'(k * odwm_pkg::OCT_SPAN);
            end
        end
        rem = odwm_pkg::ARG_W'(angle - oct_base);
        arg = oct[0] ? odwm_pkg::ARG_W'(odwm_pkg::OCT_SPAN) - rem : rem;
    end

    always_comb
    begin
        cmd_next.speed = speed;
        cmd_next.trim  = turn_offset;
        cmd_next.oct   = oct;
        cmd_next.tq    = odwm_pkg::tan_q(arg);
    end

    // Advance whenever the stage is empty or its contents are being taken
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

FILE: sv/odwm_mix_stage.sv
// Wheel term mixing with trim and truncation toward zero, registered.
`timescale 1ns / 1ps

module odwm_mix_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  odwm_pkg::angle_cmd_t                in_cmd,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [odwm_pkg::WHEEL_W-1:0] wheel1_speed,
    output logic signed [odwm_pkg::WHEEL_W-1:0] wheel2_speed,
    output logic signed [odwm_pkg::WHEEL_W-1:0] wheel3_speed,
    output logic signed [odwm_pkg::WHEEL_W-1:0] wheel4_speed
);

    localparam int F     = odwm_pkg::TAN_FRAC_BITS;
    localparam int V_W   = F + odwm_pkg::WHEEL_W;
    localparam int PROD_W = odwm_pkg::SPEED_W + odwm_pkg::TQ_W;

    logic [PROD_W-1:0]                  prod;
    logic [V_W-1:0]                     mag_s;
    logic [V_W-1:0]                     mag_t;
    logic [odwm_pkg::TRIM_W-1:0]        cw;
    logic [odwm_pkg::TRIM_W-1:0]        ccw;
    logic [V_W-1:0]                     cw_sh;
    logic [V_W-1:0]                     ccw_sh;
    logic [V_W-1:0]                     v     [odwm_pkg::N_WHEELS];
    logic [V_W-1:0]                     v_adj [odwm_pkg::N_WHEELS];
    logic [odwm_pkg::WHEEL_W-1:0]       wheel_next [odwm_pkg::N_WHEELS];
    logic [odwm_pkg::WHEEL_W-1:0]       wheel_reg  [odwm_pkg::N_WHEELS];
    logic                               valid_reg;
    logic                               valid_next;

    always_comb
    begin
        prod   = PROD_W'(in_cmd.speed) * PROD_W'(in_cmd.tq);
        mag_t  = V_W'(prod);
        mag_s  = V_W'({in_cmd.speed, {F{1'b0}}});
        // Clockwise trim is the magnitude of a negative offset (-128 gives 128)
        cw     = in_cmd.trim[odwm_pkg::TRIM_W-1] ? odwm_pkg::TRIM_W'(-in_cmd.trim) : '0;
        ccw    = (!in_cmd.trim[odwm_pkg::TRIM_W-1]) ? unsigned'(in_cmd.trim) : '0;
        cw_sh  = V_W'({cw, {F{1'b0}}});
        ccw_sh = V_W'({ccw, {F{1'b0}}});
    end

    always_comb
    begin
        for (int w = 0; w < odwm_pkg::N_WHEELS; w++)
        begin
            case (odwm_pkg::OCT_MAP[in_cmd.oct][w])
                odwm_pkg::TERM_POS_S: v[w] = mag_s - cw_sh;
                odwm_pkg::TERM_NEG_S: v[w] = ccw_sh - mag_s;
                odwm_pkg::TERM_POS_T: v[w] = mag_t - cw_sh;
                odwm_pkg::TERM_NEG_T: v[w] = ccw_sh - mag_t;
                default:              v[w] = '0;
            endcase
            // Bias negative values so the arithmetic shift rounds toward zero
            v_adj[w] = v[w][V_W-1] ? v[w] + V_W'({F{1'b1}}) : v[w];
            wheel_next[w] = v_adj[w][V_W-1:F];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            wheel_reg <= wheel_next;
        end
    end

    assign out_valid    = valid_reg;
    assign wheel1_speed = signed'(wheel_reg[0]);
    assign wheel2_speed = signed'(wheel_reg[1]);
    assign wheel3_speed = signed'(wheel_reg[2]);
    assign wheel4_speed = signed'(wheel_reg[3]);

endmodule

FILE: sv/omni_drive_wheel_mixer_core.sv
// Top level of the omni-drive wheel mixer: stream ports and the two-stage pipeline.
`timescale 1ns / 1ps

// Channel  | Dir | tdata bits | Fields, lowest bit first
// ---------+-----+------------+---------------------------------------------------
// s_axis   | in  | 32         | speed[6:0], heading_deg[17:7], turn_offset[25:18]
// m_axis   | out | 40         | wheel1..wheel4 speed, 9 bits each from bit 0
//
// One transaction is accepted per cycle when the pipeline is flowing; each
// command passes through the registered angle stage (modulo reduction,
// octant split, tangent lookup) and then the registered mixing stage
// (speed times tangent, trim, truncation).
// Reset clears the valid flags of both stages; the payload registers are not
// reset. A stall on m_axis holds the result register and backs up through the
// stages; a stage still takes a new transaction whenever its own contents leave.

module omni_drive_wheel_mixer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // speed, heading_deg, turn_offset, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // wheel1, wheel2, wheel3, wheel4, zero pad
);

    localparam int HEAD_LO = odwm_pkg::SPEED_W;
    localparam int TRIM_LO = HEAD_LO + odwm_pkg::HEADING_W;
    localparam int IN_USED = TRIM_LO + odwm_pkg::TRIM_W;
    localparam int OUT_USED = odwm_pkg::N_WHEELS * odwm_pkg::WHEEL_W;

    logic [odwm_pkg::SPEED_W-1:0]          speed;
    logic signed [odwm_pkg::HEADING_W-1:0] heading_deg;
    logic signed [odwm_pkg::TRIM_W-1:0]    turn_offset;
    logic                                  angle_valid;
    logic                                  mix_ready;
    odwm_pkg::angle_cmd_t                  angle_cmd;
    logic signed [odwm_pkg::WHEEL_W-1:0]   wheel1_speed;
    logic signed [odwm_pkg::WHEEL_W-1:0]   wheel2_speed;
    logic signed [odwm_pkg::WHEEL_W-1:0]   wheel3_speed;
    logic signed [odwm_pkg::WHEEL_W-1:0]   wheel4_speed;

    // Unpack the command transaction
    assign speed       = s_axis_tdata[HEAD_LO-1:0];
    assign heading_deg = signed'(s_axis_tdata[TRIM_LO-1:HEAD_LO]);
    assign turn_offset = signed'(s_axis_tdata[IN_USED-1:TRIM_LO]);

    odwm_angle_stage u_angle
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .speed       (speed),
        .heading_deg (heading_deg),
        .turn_offset (turn_offset),
        .out_valid   (angle_valid),
        .out_ready   (mix_ready),
        .out_cmd     (angle_cmd)
    );

    odwm_mix_stage u_mix
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (angle_valid),
        .in_ready     (mix_ready),
        .in_cmd       (angle_cmd),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .wheel1_speed (wheel1_speed),
        .wheel2_speed (wheel2_speed),
        .wheel3_speed (wheel3_speed),
        .wheel4_speed (wheel4_speed)
    );

    // Pack the result transaction, wheel one lowest
    assign m_axis_tdata = {{(40 - OUT_USED){1'b0}},
                           wheel4_speed, wheel3_speed, wheel2_speed, wheel1_speed};

endmodule
